### hw/rtl/cfr_pkg.sv
// Shared types and constants for the color frame receiver.
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int unsigned POS_W         = 5;
  localparam int unsigned FRAME_MIN_LEN = 25;
  localparam int unsigned MAGIC_LEN     = 4;
  localparam int unsigned RED_START     = 4;
  localparam int unsigned GREEN_START   = 8;
  localparam int unsigned BLUE_START    = 12;
  localparam int unsigned SEED_START    = 16;
  localparam int unsigned SEED_END      = 24;

  // Magic word "WOOF", first byte at index 0.
  localparam logic [7:0] MAGIC_BYTES [MAGIC_LEN] = '{8'h57, 8'h4F, 8'h4F, 8'h46};

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_MAGIC    = 2'd1,
    STATUS_SHORT        = 2'd2,
    STATUS_BAD_CHECKSUM = 2'd3
  } status_t;

  // Packed so that status lands in the lowest bits.
  typedef struct packed {
    logic [63:0] next_seed;
    logic [31:0] blue_word;
    logic [31:0] green_word;
    logic [31:0] red_word;
    status_t     status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

### hw/rtl/cfr_frame_parser.sv
// Per-frame state: byte position, running XOR, magic check and field captures.
`timescale 1ns / 1ps

module cfr_frame_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_fire,   // a word is accepted this cycle
  input  logic [7:0]       frame_byte,
  input  logic             last_byte,
  output cfr_pkg::result_t result       // valid when byte_fire && last_byte
);

  logic [cfr_pkg::POS_W-1:0] byte_position;
  logic [7:0]                xor_running;
  logic                      magic_matches;
  logic [31:0]               red_capture;
  logic [31:0]               green_capture;
  logic [31:0]               blue_capture;
  logic [63:0]               seed_capture;

  logic in_magic;
  logic magic_ok;

  assign in_magic = (byte_position < cfr_pkg::POS_W'(cfr_pkg::MAGIC_LEN));
  assign magic_ok = magic_matches &&
                    (!in_magic || frame_byte == cfr_pkg::MAGIC_BYTES[byte_position[1:0]]);

  always_comb begin
    result = '0;
    if (!magic_ok) begin
      result.status = cfr_pkg::STATUS_BAD_MAGIC;
    end else if (byte_position < cfr_pkg::POS_W'(cfr_pkg::FRAME_MIN_LEN - 1)) begin
      // Frame length including the final byte is under the minimum.
      result.status = cfr_pkg::STATUS_SHORT;
    end else if (xor_running != frame_byte) begin
      result.status = cfr_pkg::STATUS_BAD_CHECKSUM;
    end else begin
      result.status = cfr_pkg::STATUS_OK;
    end
    if (result.status == cfr_pkg::STATUS_OK) begin
      result.red_word   = red_capture;
      result.green_word = green_capture;
      result.blue_word  = blue_capture;
      result.next_seed  = seed_capture;
    end else begin
      result.next_seed  = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (byte_fire && last_byte)) begin
      byte_position <= '0;
      xor_running   <= '0;
      magic_matches <= 1'b1;
      red_capture   <= '0;
      green_capture <= '0;
      blue_capture  <= '0;
      seed_capture  <= '0;
    end else if (byte_fire) begin
      magic_matches <= magic_ok;
      xor_running   <= xor_running ^ frame_byte;
      if (byte_position < cfr_pkg::POS_W'(cfr_pkg::FRAME_MIN_LEN)) begin
        byte_position <= byte_position + 1'b1;
      end
      if (byte_position >= cfr_pkg::POS_W'(cfr_pkg::RED_START) &&
          byte_position <  cfr_pkg::POS_W'(cfr_pkg::GREEN_START)) begin
        red_capture <= {red_capture[23:0], frame_byte};
      end else if (byte_position >= cfr_pkg::POS_W'(cfr_pkg::GREEN_START) &&
                   byte_position <  cfr_pkg::POS_W'(cfr_pkg::BLUE_START)) begin
        green_capture <= {green_capture[23:0], frame_byte};
      end else if (byte_position >= cfr_pkg::POS_W'(cfr_pkg::BLUE_START) &&
                   byte_position <  cfr_pkg::POS_W'(cfr_pkg::SEED_START)) begin
        blue_capture <= {blue_capture[23:0], frame_byte};
      end else if (byte_position >= cfr_pkg::POS_W'(cfr_pkg::SEED_START) &&
                   byte_position <  cfr_pkg::POS_W'(cfr_pkg::SEED_END)) begin
        seed_capture <= {seed_capture[55:0], frame_byte};
      end
    end
  end

endmodule

### hw/rtl/cfr_result_reg.sv
// Output register that holds one result word until the sink takes it.
`timescale 1ns / 1ps

module cfr_result_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  cfr_pkg::result_t             result,
  output logic                         free,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cfr_pkg::TDATA_W-1:0]  m_tdata
);

  cfr_pkg::result_t held;

  assign free    = !m_tvalid || m_tready;
  assign m_tdata = {{(cfr_pkg::TDATA_W - cfr_pkg::RESULT_W){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

### hw/rtl/color_frame_receiver.sv
// Top level of the color frame receiver: byte stream in, one result word per frame out.
`timescale 1ns / 1ps

// Channel  Dir  Fields (lowest bit up)                                   Handshake
// s_axis   in   tdata: frame_byte[7:0]; tlast: last_byte                  s_tvalid/s_tready
// m_axis   out  tdata: status[1:0], red_word[33:2], green_word[65:34],    m_tvalid/m_tready
//               blue_word[97:66], next_seed[161:98], zero fill to 168
//
// The frame state registers absorb every accepted byte, and the final byte turns
// into a result word loaded straight into the output register. Throughput is
// one byte per cycle, set by the frame state update, unless a final byte waits.
// Bytes that are not final are taken even while a result word waits; a final
// byte waits only until the output register is free or being emptied.
// Reset (rst, synchronous) clears the frame state and drops m_tvalid.
module color_frame_receiver (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // frame_byte[7:0]
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata    // status, red, green, blue, next_seed, zero fill
);

  logic             out_free;
  logic             byte_fire;
  cfr_pkg::result_t result;

  // A final byte needs room in the output register; other bytes never do.
  assign s_tready  = out_free || !s_tlast;
  assign byte_fire = s_tvalid && s_tready;

  cfr_frame_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_fire  (byte_fire),
    .frame_byte (s_tdata),
    .last_byte  (s_tlast),
    .result     (result)
  );

  cfr_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (byte_fire && s_tlast),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### test/color_frame_receiver_tb.sv
// Self-checking testbench for color_frame_receiver: directed byte table, random frames, predictor.
`timescale 1ns / 1ps

module color_frame_receiver_tb;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_BYTES  = 1500;
  localparam int unsigned IDLE_PERCENT  = 6;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_AFTER    = 1000;
  localparam int unsigned STEADY_FROM   = 600;
  localparam int unsigned STEADY_TO     = 1000;
  localparam int unsigned DRAIN_CYCLES  = 8;

  logic           clk      = 1'b0;
  logic           rst      = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [7:0]     s_tdata  = '0;
  logic           s_tlast  = 1'b0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [167:0]   m_tdata;

  color_frame_receiver u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  int unsigned cycle_count    = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatch_count = 0;
  logic        hold_off       = 1'b0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Frame results still owed by the block, oldest first.
  cfr_pkg::result_t expected_frame_results[$];

  // Predictor copy of the frame state.
  logic [cfr_pkg::POS_W-1:0] frame_len;
  logic [7:0]                frame_xor;
  logic                      magic_ok;
  logic [31:0]               red_acc;
  logic [31:0]               green_acc;
  logic [31:0]               blue_acc;
  logic [63:0]               seed_acc;

  task automatic clear_frame_state();
    frame_len = '0;
    frame_xor = '0;
    magic_ok  = 1'b1;
    red_acc   = '0;
    green_acc = '0;
    blue_acc  = '0;
    seed_acc  = '0;
  endtask

  // Folds one accepted word into the frame state; on the final word it
  // yields the frame result and starts a fresh frame.
  task automatic absorb_frame_byte(input logic [7:0] b, input logic last,
                                   output bit produced, output cfr_pkg::result_t res);
    logic [cfr_pkg::POS_W-1:0] pos;
    pos      = frame_len;
    produced = 1'b0;
    res      = '0;
    if (pos < cfr_pkg::MAGIC_LEN && b != cfr_pkg::MAGIC_BYTES[pos[1:0]]) magic_ok = 1'b0;
    if (!last) begin
      if (pos >= cfr_pkg::RED_START && pos < cfr_pkg::GREEN_START)
        red_acc = {red_acc[23:0], b};
      else if (pos >= cfr_pkg::GREEN_START && pos < cfr_pkg::BLUE_START)
        green_acc = {green_acc[23:0], b};
      else if (pos >= cfr_pkg::BLUE_START && pos < cfr_pkg::SEED_START)
        blue_acc = {blue_acc[23:0], b};
      else if (pos >= cfr_pkg::SEED_START && pos < cfr_pkg::SEED_END)
        seed_acc = {seed_acc[55:0], b};
      frame_xor = frame_xor ^ b;
      if (pos < cfr_pkg::FRAME_MIN_LEN) frame_len = pos + 1'b1;
    end else begin
      produced = 1'b1;
      if (!magic_ok) res.status = cfr_pkg::STATUS_BAD_MAGIC;
      else if (pos + 1 < cfr_pkg::FRAME_MIN_LEN) res.status = cfr_pkg::STATUS_SHORT;
      else if (frame_xor != b) res.status = cfr_pkg::STATUS_BAD_CHECKSUM;
      else res.status = cfr_pkg::STATUS_OK;
      if (res.status == cfr_pkg::STATUS_OK) begin
        res.red_word   = red_acc;
        res.green_word = green_acc;
        res.blue_word  = blue_acc;
        res.next_seed  = seed_acc;
      end else begin
        res.next_seed  = '1;
      end
      clear_frame_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s at %0t ns: got %h, want %h", what, $time, got, want);
    mismatch_count++;
  endtask

  // Both sides run without idles inside this window.
  function automatic bit steady_window();
    return cycle_count >= STEADY_FROM && cycle_count < STEADY_TO;
  endfunction

  // Offers one word and returns at the edge where it is taken. The valid is
  // only lowered when an idle gap is inserted, never between back-to-back words.
  task automatic offer_byte(input logic [7:0] b, input logic last);
    while (!steady_window() && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    bytes_accepted++;
  endtask

  task automatic send_checked_byte(input logic [7:0] b, input logic last);
    bit               produced;
    cfr_pkg::result_t res;
    offer_byte(b, last);
    absorb_frame_byte(b, last, produced, res);
    if (produced) expected_frame_results = {expected_frame_results, res};
  endtask

  // One random frame. Most are well formed with random content; the rest
  // carry a bad checksum, a broken magic word, a short length or pure noise.
  task automatic send_random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned bad_at;
    bit          solid_fill;
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [7:0]  sum;
    kind       = $urandom_range(99);
    solid_fill = ($urandom_range(9) == 0);
    case ($urandom_range(19))
      0:       len = $urandom_range(70, 41);
      1, 2, 3: len = $urandom_range(40, 26);
      default: len = cfr_pkg::FRAME_MIN_LEN;
    endcase
    if (kind >= 90 && kind < 96) len = $urandom_range(cfr_pkg::FRAME_MIN_LEN - 1, 1);
    if (kind >= 96) len = $urandom_range(40, 1);
    sum = '0;
    for (int unsigned i = 0; i + 1 < len; i++) begin
      if (solid_fill) b = $urandom_range(1) ? 8'hFF : 8'h00;
      else b = 8'($urandom_range(255));
      if (i < cfr_pkg::MAGIC_LEN && kind < 96) b = cfr_pkg::MAGIC_BYTES[i];
      body = {body, b};
    end
    if (kind >= 82 && kind < 90) begin
      bad_at = $urandom_range(cfr_pkg::MAGIC_LEN - 1);
      body[bad_at] = body[bad_at] ^ 8'($urandom_range(255, 1));
    end
    foreach (body[i]) sum = sum ^ body[i];
    // Bad-checksum frames flip at least one bit of the final word.
    if (kind >= 70 && kind < 82) sum = sum ^ 8'($urandom_range(255, 1));
    else if (kind >= 96) sum = 8'($urandom_range(255));
    foreach (body[i]) send_checked_byte(body[i], 1'b0);
    send_checked_byte(sum, 1'b1);
  endtask

  // Directed rows: short and malformed frames whose status is plain to see.
  typedef struct {
    logic [7:0]        frame_byte;
    logic              last_byte;
    bit                typed;
    cfr_pkg::status_t  want_status;
  } frame_row_t;

  frame_row_t stim_rows[$];

  task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                         input cfr_pkg::status_t want);
    frame_row_t row;
    row.frame_byte  = b;
    row.last_byte   = last;
    row.typed       = typed;
    row.want_status = want;
    stim_rows = {stim_rows, row};
  endtask

  // Output side: checks each taken result word, then picks next cycle's ready.
  always @(posedge clk) begin
    cfr_pkg::result_t got;
    cfr_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[cfr_pkg::RESULT_W-1:0];
      if (expected_frame_results.size() == 0) begin
        report_mismatch("unexpected result status", 64'(got.status), '0);
      end else begin
        want = expected_frame_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.red_word !== want.red_word)
          report_mismatch("red_word", 64'(got.red_word), 64'(want.red_word));
        if (got.green_word !== want.green_word)
          report_mismatch("green_word", 64'(got.green_word), 64'(want.green_word));
        if (got.blue_word !== want.blue_word)
          report_mismatch("blue_word", 64'(got.blue_word), 64'(want.blue_word));
        if (got.next_seed !== want.next_seed)
          report_mismatch("next_seed", got.next_seed, want.next_seed);
        if (m_tdata[cfr_pkg::TDATA_W-1:cfr_pkg::RESULT_W] !== '0)
          report_mismatch("zero fill",
                          64'(m_tdata[cfr_pkg::TDATA_W-1:cfr_pkg::RESULT_W]), '0);
      end
    end
    if (hold_off) m_tready <= 1'b0;
    else if (steady_window()) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Long receiver stall while words keep coming, so the block backs up.
  initial begin
    wait (bytes_accepted >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    bit               produced;
    cfr_pkg::result_t res;
    cfr_pkg::result_t typed_res;

    clear_frame_state();
    // One-word frames: extremes, then a final word that is also a magic byte.
    add_row(8'hFF, 1'b1, 1'b1, cfr_pkg::STATUS_BAD_MAGIC);
    add_row(8'h00, 1'b1, 1'b1, cfr_pkg::STATUS_BAD_MAGIC);
    add_row(8'h57, 1'b1, 1'b1, cfr_pkg::STATUS_SHORT);
    // Three words matching the start of the magic word.
    add_row(8'h57, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h4F, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h4F, 1'b1, 1'b1, cfr_pkg::STATUS_SHORT);
    // Final word in the magic range is wrong.
    add_row(8'h57, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h4F, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h00, 1'b1, 1'b1, cfr_pkg::STATUS_BAD_MAGIC);
    // Full magic word, then too few words with a matching checksum.
    add_row(8'h57, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h4F, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h4F, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h46, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h11, 1'b1, 1'b1, cfr_pkg::STATUS_SHORT);
    // Bad magic outranks a short frame.
    add_row(8'h00, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h4F, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h4F, 1'b1, 1'b1, cfr_pkg::STATUS_BAD_MAGIC);
    // Only the fourth magic byte is wrong.
    add_row(8'h57, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h4F, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h4F, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'h47, 1'b0, 1'b0, cfr_pkg::STATUS_OK);
    add_row(8'hFF, 1'b1, 1'b1, cfr_pkg::STATUS_BAD_MAGIC);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      offer_byte(stim_rows[i].frame_byte, stim_rows[i].last_byte);
      absorb_frame_byte(stim_rows[i].frame_byte, stim_rows[i].last_byte, produced, res);
      if (produced) begin
        if (stim_rows[i].typed) begin
          // Every typed row is a rejected frame: zero colors, seed all ones.
          typed_res           = '0;
          typed_res.status    = stim_rows[i].want_status;
          typed_res.next_seed = '1;
          expected_frame_results = {expected_frame_results, typed_res};
        end else begin
          expected_frame_results = {expected_frame_results, res};
        end
      end
    end

    while (bytes_accepted < RANDOM_BYTES + stim_rows.size()) send_random_frame();
    s_tvalid <= 1'b0;

    while (expected_frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
